/* src/sthc_pkg.sv */
// Shared widths, register indexes and reset values for the Schmitt trigger block.
package sthc_pkg;

  localparam int TIME_WIDTH    = 16;
  localparam int LEVEL_WIDTH   = 16;
  localparam int ELAPSED_WIDTH = 10;
  localparam int FIELD_WIDTH   = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int SUM_WIDTH     =
      ((TIME_WIDTH > ELAPSED_WIDTH) ? TIME_WIDTH : ELAPSED_WIDTH) + 1;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_HIGH_THRESHOLD = 2'd0,
    REG_LOW_THRESHOLD  = 2'd1,
    REG_HOLD_TIME      = 2'd2,
    REG_COOLDOWN_TIME  = 2'd3
  } cfg_reg_t;

  localparam logic [LEVEL_WIDTH-1:0] HIGH_THRESHOLD_RESET = LEVEL_WIDTH'(32768);
  localparam logic [LEVEL_WIDTH-1:0] LOW_THRESHOLD_RESET  = LEVEL_WIDTH'(19661);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

endpackage

/* src/schmitt_trigger_hold_cooldown.sv */
// Schmitt trigger with minimum hold time and re-arm cooldown, two-register pipeline.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    level, elapsed_ms
//   out      out_valid / out_stall  level_echo, is_active, fired, released,
//                                   held_ms_out, cooldown_left_ms
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless out_stall holds a valid result in the result register.
// The trigger state updates as an item moves from the input register into
// the result register, so consecutive items see each other's effect.
// rst clears the state, the pipeline and the registers to their reset values.
// out_stall on a valid result freezes the result register and the trigger state;
// in_stall rises only when the input register is full and cannot move on.
// cfg_ready is always high.
module schmitt_trigger_hold_cooldown
  import sthc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FIELD_WIDTH-1:0]   level,
  input  logic [ELAPSED_WIDTH-1:0] elapsed_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIELD_WIDTH-1:0]   level_echo,
  output logic                     is_active,
  output logic                     fired,
  output logic                     released,
  output logic [FIELD_WIDTH-1:0]   held_ms_out,
  output logic [FIELD_WIDTH-1:0]   cooldown_left_ms,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [FIELD_WIDTH-1:0]   cfg_data
);

  logic [LEVEL_WIDTH-1:0] high_threshold;
  logic [LEVEL_WIDTH-1:0] low_threshold;
  logic [TIME_WIDTH-1:0]  hold_time;
  logic [TIME_WIDTH-1:0]  cooldown_time;

  logic                     active_flag;
  logic [TIME_WIDTH-1:0]    held_time;
  logic [TIME_WIDTH-1:0]    cooldown_left;

  logic                     in_q_valid;
  logic [LEVEL_WIDTH-1:0]   level_q;
  logic [ELAPSED_WIDTH-1:0] elapsed_q;

  logic [LEVEL_WIDTH-1:0]   level_out;

  logic                     advance;
  logic                     move;
  logic                     active_next;
  logic                     fired_next;
  logic                     released_next;
  logic [TIME_WIDTH-1:0]    held_next;
  logic [TIME_WIDTH-1:0]    cooldown_next;
  logic [TIME_WIDTH-1:0]    cooldown_dec;
  logic [SUM_WIDTH-1:0]     held_sum;
  logic [TIME_WIDTH-1:0]    held_sat;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign move      = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RESET;
      low_threshold  <= LOW_THRESHOLD_RESET;
      hold_time      <= '0;
      cooldown_time  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HIGH_THRESHOLD: high_threshold <= LEVEL_WIDTH'(cfg_data);
        REG_LOW_THRESHOLD:  low_threshold  <= LEVEL_WIDTH'(cfg_data);
        REG_HOLD_TIME:      hold_time      <= TIME_WIDTH'(cfg_data);
        REG_COOLDOWN_TIME:  cooldown_time  <= TIME_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      level_q   <= LEVEL_WIDTH'(level);
      elapsed_q <= elapsed_ms;
    end
  end

  // trigger step
  always_comb begin
    if (SUM_WIDTH'(cooldown_left) > SUM_WIDTH'(elapsed_q)) begin
      cooldown_dec = TIME_WIDTH'(SUM_WIDTH'(cooldown_left) - SUM_WIDTH'(elapsed_q));
    end else begin
      cooldown_dec = '0;
    end
    held_sum = SUM_WIDTH'(held_time) + SUM_WIDTH'(elapsed_q);
    held_sat = (held_sum > SUM_WIDTH'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(held_sum);

    active_next   = active_flag;
    fired_next    = 1'b0;
    released_next = 1'b0;
    held_next     = held_time;
    cooldown_next = cooldown_dec;
    if (active_flag) begin
      held_next = held_sat;
      if (held_sat >= hold_time && level_q < low_threshold) begin
        active_next   = 1'b0;
        released_next = 1'b1;
        cooldown_next = cooldown_time;
        held_next     = '0;
      end
    end else if (cooldown_dec == '0 && level_q >= high_threshold) begin
      active_next = 1'b1;
      fired_next  = 1'b1;
      held_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag   <= 1'b0;
      held_time     <= '0;
      cooldown_left <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (move) begin
        active_flag   <= active_next;
        held_time     <= held_next;
        cooldown_left <= cooldown_next;
      end
      if (advance) begin
        out_valid <= in_q_valid;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (move) begin
      level_out <= level_q;
      fired     <= fired_next;
      released  <= released_next;
    end
  end

  assign level_echo       = FIELD_WIDTH'(level_out);
  assign is_active        = active_flag;
  assign held_ms_out      = FIELD_WIDTH'(held_time);
  assign cooldown_left_ms = FIELD_WIDTH'(cooldown_left);

endmodule

/* src/sthc_checker.sv */
// Port-level checks for the Schmitt trigger block, bound to the top level.
module sthc_checker
  import sthc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [FIELD_WIDTH-1:0] level_echo,
  input logic                   is_active,
  input logic                   fired,
  input logic                   released,
  input logic [FIELD_WIDTH-1:0] held_ms_out,
  input logic [FIELD_WIDTH-1:0] cooldown_left_ms
);

  a_one_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fired && released))
    else $error("fired and released in the same step");

  a_edge_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fired || released) |-> (is_active == fired))
    else $error("edge flag disagrees with trigger state");

  // hold time only grows while active and is cleared on every transition
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_active |-> held_ms_out == '0)
    else $error("nonzero hold time while inactive");

  a_fire_cooldown: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> cooldown_left_ms == '0)
    else $error("fired with cooldown remaining");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level_echo))
    else $error("stalled result changed");

endmodule

bind schmitt_trigger_hold_cooldown sthc_checker u_sthc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .level_echo       (level_echo),
  .is_active        (is_active),
  .fired            (fired),
  .released         (released),
  .held_ms_out      (held_ms_out),
  .cooldown_left_ms (cooldown_left_ms)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Schmitt trigger with hold time and cooldown.
module tb;
  import sthc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_OFF    = 400;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0]   level;
    logic [ELAPSED_WIDTH-1:0] elapsed;
  } sample_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] level_echo;
    logic                   is_active;
    logic                   fired;
    logic                   released;
    logic [FIELD_WIDTH-1:0] held;
    logic [FIELD_WIDTH-1:0] cool;
  } trig_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FIELD_WIDTH-1:0]   level = '0;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [FIELD_WIDTH-1:0]   level_echo;
  logic                     is_active;
  logic                     fired;
  logic                     released;
  logic [FIELD_WIDTH-1:0]   held_ms_out;
  logic [FIELD_WIDTH-1:0]   cooldown_left_ms;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [FIELD_WIDTH-1:0]   cfg_data = '0;

  schmitt_trigger_hold_cooldown i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .level            (level),
    .elapsed_ms       (elapsed_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .level_echo       (level_echo),
    .is_active        (is_active),
    .fired            (fired),
    .released         (released),
    .held_ms_out      (held_ms_out),
    .cooldown_left_ms (cooldown_left_ms),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  sample_t   sample_queue[$];
  trig_out_t expected_outs[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        in_done = 1'b0;
  bit        steady = 1'b0;
  bit        squeeze = 1'b0;
  bit        squeezed = 1'b0;
  int        hold_left = 0;

  // shadow registers and trigger state
  logic [LEVEL_WIDTH-1:0] r_high = HIGH_THRESHOLD_RESET;
  logic [LEVEL_WIDTH-1:0] r_low  = LOW_THRESHOLD_RESET;
  logic [TIME_WIDTH-1:0]  r_hold = '0;
  logic [TIME_WIDTH-1:0]  r_cool = '0;
  logic                   t_active = 1'b0;
  logic [TIME_WIDTH-1:0]  t_held = '0;
  logic [TIME_WIDTH-1:0]  t_cool = '0;

  function automatic trig_out_t step_trigger(input logic [FIELD_WIDTH-1:0] lv,
                                             input logic [ELAPSED_WIDTH-1:0] dt);
    logic [SUM_WIDTH-1:0] sum;
    trig_out_t r;
    r.fired    = 1'b0;
    r.released = 1'b0;
    // countdown comes first so firing is allowed on the step it expires
    if (t_cool != 0) t_cool = (t_cool > TIME_WIDTH'(dt)) ? t_cool - TIME_WIDTH'(dt) : '0;
    if (t_active) begin
      sum = SUM_WIDTH'(t_held) + SUM_WIDTH'(dt);
      t_held = (sum > SUM_WIDTH'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
      if (t_held >= r_hold && lv < r_low) begin
        t_active   = 1'b0;
        r.released = 1'b1;
        t_cool     = r_cool;
        t_held     = '0;
      end
    end else if (t_cool == 0 && lv >= r_high) begin
      t_active = 1'b1;
      r.fired  = 1'b1;
      t_held   = '0;
    end
    r.level_echo = lv;
    r.is_active  = t_active;
    r.held       = t_held;
    r.cool       = t_cool;
    return r;
  endfunction

  // sample driver
  always @(negedge clk) begin
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_done) begin
      // stalled: hold payload
    end else if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
      nxt = sample_queue.pop_front();
      in_valid   <= 1'b1;
      level      <= nxt.level;
      elapsed_ms <= nxt.elapsed;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result-side stall, with one long hold-off
  always @(negedge clk) begin
    if (squeeze && !squeezed) begin
      squeezed  = 1'b1;
      hold_left = HOLD_OFF;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 37);
    end
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    trig_out_t want;
    trig_out_t got;
    if (rst) begin
      r_high      = HIGH_THRESHOLD_RESET;
      r_low       = LOW_THRESHOLD_RESET;
      r_hold      = '0;
      r_cool      = '0;
      t_active    = 1'b0;
      t_held      = '0;
      t_cool      = '0;
      in_done     = 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HIGH_THRESHOLD: r_high = cfg_data[LEVEL_WIDTH-1:0];
          REG_LOW_THRESHOLD:  r_low  = cfg_data[LEVEL_WIDTH-1:0];
          REG_HOLD_TIME:      r_hold = cfg_data[TIME_WIDTH-1:0];
          REG_COOLDOWN_TIME:  r_cool = cfg_data[TIME_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_outs.push_back(step_trigger(level, elapsed_ms));
      if (out_valid && !out_stall) begin
        got = '{level_echo, is_active, fired, released, held_ms_out, cooldown_left_ms};
        if (expected_outs.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = expected_outs.pop_front();
          if (got.level_echo != want.level_echo) begin
            errors++;
            $display("%0t level_echo: expected %h actual %h", $time,
                     want.level_echo, got.level_echo);
          end
          if (got.is_active != want.is_active) begin
            errors++;
            $display("%0t is_active: expected %b actual %b", $time,
                     want.is_active, got.is_active);
          end
          if (got.fired != want.fired) begin
            errors++;
            $display("%0t fired: expected %b actual %b", $time, want.fired, got.fired);
          end
          if (got.released != want.released) begin
            errors++;
            $display("%0t released: expected %b actual %b", $time,
                     want.released, got.released);
          end
          if (got.held != want.held) begin
            errors++;
            $display("%0t held_ms_out: expected %h actual %h", $time, want.held, got.held);
          end
          if (got.cool != want.cool) begin
            errors++;
            $display("%0t cooldown_left_ms: expected %h actual %h", $time,
                     want.cool, got.cool);
          end
        end
      end
      in_done = in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [FIELD_WIDTH-1:0] lv,
                             input logic [ELAPSED_WIDTH-1:0] dt);
    sample_queue.push_back('{lv, dt});
  endtask

  // block is idle once every sample went in and every result came out
  task automatic drain;
    while (sample_queue.size() != 0 || in_valid || expected_outs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [FIELD_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic set_config(input logic [FIELD_WIDTH-1:0] hi, input logic [FIELD_WIDTH-1:0] lo,
                            input logic [FIELD_WIDTH-1:0] hold,
                            input logic [FIELD_WIDTH-1:0] cool);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HOLD_TIME, hold);
    write_reg(REG_COOLDOWN_TIME, cool);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int p;
    int n;
    int r;
    logic [FIELD_WIDTH-1:0]   hi;
    logic [FIELD_WIDTH-1:0]   lo;
    logic [FIELD_WIDTH-1:0]   hold;
    logic [FIELD_WIDTH-1:0]   cool;
    logic [FIELD_WIDTH-1:0]   tmp;
    logic [FIELD_WIDTH-1:0]   lv;
    logic [ELAPSED_WIDTH-1:0] dt;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds: fire exactly at high, release on zero elapsed time
    push_sample(16'd0, 10'd0);
    push_sample(16'd32767, 10'd0);
    push_sample(16'd32768, 10'd0);
    push_sample(16'd19661, 10'd1023);
    push_sample(16'd19660, 10'd0);
    push_sample(16'hFFFF, 10'd0);
    drain;

    // hold time gates release, cooldown blocks refire, refire as cooldown expires
    set_config(16'd40000, 16'd20000, 16'd100, 16'd50);
    push_sample(16'hFFFF, 10'd1);
    push_sample(16'd0, 10'd50);
    push_sample(16'd0, 10'd60);
    push_sample(16'hFFFF, 10'd0);
    push_sample(16'hFFFF, 10'd20);
    push_sample(16'hFFFF, 10'd30);
    push_sample(16'd0, 10'd1023);
    push_sample(16'd0, 10'd1023);
    push_sample(16'd39999, 10'd5);
    drain;

    // low threshold above high: no refire on the release step
    set_config(16'd100, 16'd60000, 16'd0, 16'd0);
    push_sample(16'd100, 10'd3);
    push_sample(16'd50000, 10'd0);
    push_sample(16'd50000, 10'd0);
    push_sample(16'd59999, 10'd7);
    drain;

    set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    push_sample(16'd0, 10'd0);
    push_sample(16'd0, 10'd1023);
    push_sample(16'hFFFF, 10'd1023);
    drain;

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'hFFFF, 10'd1023);
    push_sample(16'hFFFE, 10'd1023);
    drain;

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          // long steps saturate the hold time and drain a full cooldown
          hi = '0; lo = '1; hold = '1; cool = '1;
        end
        1: begin
          hi = '1; lo = 16'd1; hold = '0; cool = '0;
        end
        default: begin
          hi = FIELD_WIDTH'($urandom);
          lo = FIELD_WIDTH'($urandom);
          if ($urandom_range(3) != 0 && lo > hi) begin
            tmp = lo; lo = hi; hi = tmp;
          end
          hold = FIELD_WIDTH'($urandom_range(2000));
          cool = FIELD_WIDTH'($urandom_range(2000));
        end
      endcase
      set_config(hi, lo, hold, cool);
      steady  = (p == 3);
      squeeze = (p == 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 5)       lv = hi;
        else if (r < 10) lv = lo;
        else if (r < 15) lv = lo - 1'b1;
        else if (r < 40) lv = FIELD_WIDTH'($urandom_range(16'hFFFF, hi));
        else if (r < 65) lv = FIELD_WIDTH'($urandom_range(lo, 0));
        else if (r < 85) lv = FIELD_WIDTH'($urandom_range(lo, hi));
        else             lv = FIELD_WIDTH'($urandom);
        r = $urandom_range(99);
        if (p == 0 && r < 80) dt = '1;
        else if (r < 10)      dt = '0;
        else if (r < 20)      dt = '1;
        else if (r < 70)      dt = ELAPSED_WIDTH'($urandom_range(200));
        else                  dt = ELAPSED_WIDTH'($urandom);
        push_sample(lv, dt);
      end
      drain;
      steady  = 1'b0;
      squeeze = 1'b0;
    end

    drain;
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
src/sthc_pkg.sv
src/schmitt_trigger_hold_cooldown.sv
src/sthc_checker.sv
verif/tb.sv
